FILE: sv/ohlm_pkg.sv
// package for the offset hit list merge engine
// action codes and the controller to datapath command and status types
`timescale 1ns / 1ps
`default_nettype none
package ohlm_pkg;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_FIRST = 3'd2;
    localparam logic [2:0] ACT_BOUND = 3'd3;
    localparam logic [2:0] ACT_LOWER = 3'd4;

    typedef struct packed {
        logic accept;
        logic list_start;
        logic rd;
        logic eval;
        logic list_end;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic lists_done;
        logic p_lt_len;
        logic step_again;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/ohlm_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ohlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/ohlm_ctrl.sv
// sequencing state machine of the merge engine
// uses ohlm_pkg command and status types
`timescale 1ns / 1ps
`default_nettype none
module ohlm_ctrl import ohlm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LIST = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WT   = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.in_query ? S_LIST : S_FIN;
                end
            end
            S_LIST: begin
                if (i_status.lists_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.list_start = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_status.p_lt_len) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_WT;
                end else begin
                    n_state = S_END;
                end
            end
            S_WT: begin
                o_cmd.eval = 1'b1;
                n_state = i_status.step_again ? S_RD : S_END;
            end
            S_END: begin
                o_cmd.list_end = 1'b1;
                n_state = S_LIST;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

FILE: sv/ohlm_dp.sv
// datapath of the merge engine: list tables, hit store, cursor walk, best value
// uses ohlm_pkg and ohlm_ram
`timescale 1ns / 1ps
`default_nettype none
module ohlm_dp import ohlm_pkg::*; #(
    parameter int MAX_LISTS         = 32,
    parameter int MAX_HITS_PER_LIST = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_hit_location,
    input  wire logic [15:0] i_seed_offset,
    input  wire logic        i_last_hit_of_list,
    input  wire logic [31:0] i_upper_bound,
    output logic             o_found,
    output logic      [31:0] o_location,
    output logic      [15:0] o_found_seed_offset,
    output logic             o_overflow
);
    localparam int LW    = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CW    = $clog2(MAX_LISTS + 1);
    localparam int PW    = (MAX_HITS_PER_LIST > 1) ? $clog2(MAX_HITS_PER_LIST) : 1;
    localparam int LENW  = $clog2(MAX_HITS_PER_LIST + 1);
    localparam int DEPTH = MAX_LISTS * MAX_HITS_PER_LIST;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LENW-1:0] r_len [MAX_LISTS];
    logic [15:0]     r_off [MAX_LISTS];
    logic [LENW-1:0] r_cur [MAX_LISTS];

    logic [CW-1:0]   r_count;
    logic [LENW-1:0] r_fill;
    logic [31:0]     r_last_ret;
    logic [2:0]      r_act;
    logic [31:0]     r_bound;
    logic [CW-1:0]   r_idx;
    logic [LENW-1:0] r_p;
    logic [31:0]     r_thr;
    logic            r_stepped;
    logic            r_any;
    logic [31:0]     r_best;
    logic [15:0]     r_best_off;
    logic            r_ovf;

    logic [LW-1:0]   idx_l, cnt_l;
    logic [LENW-1:0] cur_len;
    logic [15:0]     cur_off;
    logic [31:0]     rdata, corr;
    logic            step_again, take;
    logic            lists_full, fill_full, load_ovf;
    logic            we;
    logic [AW-1:0]   waddr, raddr;

    assign idx_l   = r_idx[LW-1:0];
    assign cnt_l   = r_count[LW-1:0];
    assign cur_len = r_len[idx_l];
    assign cur_off = r_off[idx_l];
    assign corr    = rdata - {16'd0, cur_off};

    assign lists_full = (r_count == CW'(MAX_LISTS));
    assign fill_full  = (r_fill == LENW'(MAX_HITS_PER_LIST));
    assign load_ovf   = lists_full || fill_full;
    assign we         = i_cmd.accept && (i_action == ACT_LOAD) && !load_ovf;

    assign waddr = AW'(AW'(cnt_l) * AW'(MAX_HITS_PER_LIST) + AW'(r_fill[PW-1:0]));
    assign raddr = AW'(AW'(idx_l) * AW'(MAX_HITS_PER_LIST) + AW'(r_p[PW-1:0]));

    ohlm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_hits (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_hit_location),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (r_act)
            ACT_BOUND: step_again = (rdata > r_thr);
            ACT_LOWER: step_again = !r_stepped && (corr == r_last_ret);
            default:   step_again = 1'b0;
        endcase
        if (r_act == ACT_FIRST) begin
            take = (corr > r_best);
        end else begin
            take = !r_any || (corr > r_best);
        end
    end

    assign o_status.in_query   = (i_action == ACT_FIRST) || (i_action == ACT_BOUND)
                                 || (i_action == ACT_LOWER);
    assign o_status.lists_done = (r_idx == r_count);
    assign o_status.p_lt_len   = (r_p < cur_len);
    assign o_status.step_again = step_again;

    // list bookkeeping with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fill     <= '0;
            r_last_ret <= '0;
        end else begin
            if (i_cmd.accept && i_action == ACT_CLEAR) begin
                r_count    <= '0;
                r_fill     <= '0;
                r_last_ret <= '0;
            end else if (i_cmd.accept && i_action == ACT_LOAD && !lists_full) begin
                if (i_last_hit_of_list) begin
                    r_count <= r_count + CW'(1);
                    r_fill  <= '0;
                end else if (!fill_full) begin
                    r_fill <= r_fill + LENW'(1);
                end
            end
            if (i_cmd.fin && r_any) begin
                r_last_ret <= r_best;
            end
        end
    end

    // tables and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act      <= i_action;
            r_bound    <= i_upper_bound;
            r_idx      <= '0;
            r_any      <= 1'b0;
            r_best     <= '0;
            r_best_off <= '0;
            r_ovf      <= (i_action == ACT_LOAD) && load_ovf;
            if (i_action == ACT_LOAD && !lists_full) begin
                r_off[cnt_l] <= i_seed_offset;
                if (i_last_hit_of_list) begin
                    r_len[cnt_l] <= fill_full ? r_fill : r_fill + LENW'(1);
                    r_cur[cnt_l] <= '0;
                end
            end
        end
        if (i_cmd.list_start) begin
            r_p       <= (r_act == ACT_FIRST) ? '0 : r_cur[idx_l];
            r_thr     <= r_bound - {16'd0, cur_off};
            r_stepped <= 1'b0;
        end
        if (i_cmd.eval) begin
            if (step_again) begin
                r_p       <= r_p + LENW'(1);
                r_stepped <= 1'b1;
            end else if (take) begin
                r_best     <= corr;
                r_best_off <= cur_off;
                r_any      <= 1'b1;
            end
        end
        if (i_cmd.list_end) begin
            if (r_act == ACT_BOUND || r_act == ACT_LOWER) begin
                r_cur[idx_l] <= r_p;
            end
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.fin) begin
            o_found             <= r_any;
            o_location          <= r_any ? r_best : 32'd0;
            o_found_seed_offset <= r_any ? r_best_off : 16'd0;
            o_overflow          <= r_ovf;
        end
    end
endmodule
`default_nettype wire

FILE: sv/offset_hit_list_merge_engine_unit.sv
// offset hit list merge engine, top level
// joins ohlm_ctrl and ohlm_dp, uses ohlm_pkg
//
// one input transaction gives exactly one output transaction. tuser carries the
// action (clear, load hit, first hit, next at or below bound, next lower), tlast
// closes the open list on a load. clear and load go from acceptance straight to
// the finish state, which writes the output register. a query walks the closed
// lists one after another: a start state per list, a read state and a compare
// state per hit store access and a state to close the list, then the finish
// state; every access goes through the single read port of the hit store. a new
// transaction is taken only while the engine is idle, but it is taken while the
// previous result still waits in the output register; when the receiver stalls,
// a finished result waits until the output register frees. reset clears the
// list count, the open list and the last returned location; the hit store needs
// no clearing since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
module offset_hit_list_merge_engine_unit import ohlm_pkg::*; #(
    parameter int MAX_LISTS         = 32,
    parameter int MAX_HITS_PER_LIST = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [79:0] i_s_axis_tdata,  // hit_location, seed_offset, upper_bound
    input  wire logic [2:0]  i_s_axis_tuser,  // action
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [47:0] o_m_axis_tdata,  // location, found_seed_offset
    output logic      [1:0]  o_m_axis_tuser   // found, overflow
);
    t_cmd    cmd;
    t_status status;
    logic        found, overflow;
    logic [31:0] location;
    logic [15:0] found_seed_offset;

    ohlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ohlm_dp #(
        .MAX_LISTS         (MAX_LISTS),
        .MAX_HITS_PER_LIST (MAX_HITS_PER_LIST)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_action            (i_s_axis_tuser),
        .i_hit_location      (i_s_axis_tdata[31:0]),
        .i_seed_offset       (i_s_axis_tdata[47:32]),
        .i_last_hit_of_list  (i_s_axis_tlast),
        .i_upper_bound       (i_s_axis_tdata[79:48]),
        .o_found             (found),
        .o_location          (location),
        .o_found_seed_offset (found_seed_offset),
        .o_overflow          (overflow)
    );

    assign o_m_axis_tdata = {found_seed_offset, location};
    assign o_m_axis_tuser = {overflow, found};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !found) |-> (location == 32'd0 && found_seed_offset == 16'd0))
        else $error("empty result carries data");

    a_ovf_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && overflow) |-> !found)
        else $error("overflow together with found");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("accepted while busy");
endmodule
`default_nettype wire

FILE: tb/sv/offset_hit_list_merge_engine_unit_tb.sv
// testbench for offset_hit_list_merge_engine_unit: drives action transactions, predicts the
// merged high to low walk over the offset-corrected hit lists and checks every result
// depends on ohlm_pkg and offset_hit_list_merge_engine_unit
`timescale 1ns / 1ps
`default_nettype none
module offset_hit_list_merge_engine_unit_tb;
    import ohlm_pkg::*;

    localparam int N_LISTS     = 32;
    localparam int N_HITS      = 256;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        found;
        logic [31:0] location;
        logic [15:0] seed;
        logic        overflow;
    } t_hit_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;  // hit_location, seed_offset, upper_bound
    logic [2:0]  s_tuser = '0;  // action
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;       // location, found_seed_offset
    logic [1:0]  m_tuser;       // found, overflow

    bit          calm = 1'b0;
    int          err_cnt = 0;
    int unsigned cycles = 0;
    t_hit_result result_q[$];

    // merge state mirror
    int unsigned lists_closed;
    int unsigned open_fill;
    logic [31:0] prev_loc;
    int unsigned len_of[N_LISTS];
    logic [15:0] seed_of[N_LISTS];
    int unsigned cur_of[N_LISTS];
    logic [31:0] hits[N_LISTS][N_HITS];
    logic [31:0] val_pool[$];

    offset_hit_list_merge_engine_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("offset_hit_list_merge_engine_unit_tb failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    function automatic logic [31:0] corr(int unsigned l, int unsigned p);
        return hits[l][p] - {16'd0, seed_of[l]};
    endfunction

    function automatic void merge_reset();
        lists_closed = 0;
        open_fill = 0;
        prev_loc = '0;
    endfunction

    function automatic void predict_merge(logic [2:0] act, logic [31:0] hit, logic [15:0] off,
                                          logic last, logic [31:0] bound);
        t_hit_result r;
        logic [31:0] thr;
        int unsigned p;
        r = '0;
        case (act)
            ACT_CLEAR: merge_reset();
            ACT_LOAD: begin
                if (lists_closed >= N_LISTS) begin
                    r.overflow = 1'b1;
                end else begin
                    seed_of[lists_closed] = off;
                    if (open_fill < N_HITS) begin
                        hits[lists_closed][open_fill] = hit;
                        open_fill++;
                    end else begin
                        r.overflow = 1'b1;
                    end
                    if (last) begin
                        len_of[lists_closed] = open_fill;
                        cur_of[lists_closed] = 0;
                        lists_closed++;
                        open_fill = 0;
                    end
                end
            end
            ACT_FIRST: begin
                for (int l = 0; l < lists_closed; l++) begin
                    if (len_of[l] > 0 && corr(l, 0) > r.location) begin
                        r.location = corr(l, 0);
                        r.seed = seed_of[l];
                        r.found = 1'b1;
                    end
                end
            end
            ACT_BOUND, ACT_LOWER: begin
                for (int l = 0; l < lists_closed; l++) begin
                    p = cur_of[l];
                    if (act == ACT_BOUND) begin
                        thr = bound - {16'd0, seed_of[l]};
                        while (p < len_of[l] && hits[l][p] > thr) p++;
                    end else if (p < len_of[l] && corr(l, p) == prev_loc) begin
                        p++;
                    end
                    cur_of[l] = p;
                    if (p < len_of[l] && (!r.found || corr(l, p) > r.location)) begin
                        r.location = corr(l, p);
                        r.seed = seed_of[l];
                        r.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (r.found) prev_loc = r.location;
        result_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                if (m_tuser[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                    err_cnt++;
                end
                if (m_tdata[31:0] !== want.location) begin
                    $error("location: expected %h, got %h", want.location, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[47:32] !== want.seed) begin
                    $error("found_seed_offset: expected %h, got %h", want.seed, m_tdata[47:32]);
                    err_cnt++;
                end
                if (m_tuser[1] !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_tuser[1]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_op(logic [2:0] act, logic [31:0] hit = '0, logic [15:0] off = '0,
                           logic last = 1'b0, logic [31:0] bound = '0);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {bound, off, hit};
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        predict_merge(act, hit, off, last, bound);
    endtask

    // corrected value spread: narrow pools give ties between lists
    task automatic load_list(int unsigned n, logic [15:0] off, bit shuffle, int unsigned span);
        logic [31:0] v;
        v = (span == 0) ? $urandom() : $urandom_range(span * 2, span);
        for (int k = 0; k < n; k++) begin
            val_pool.push_back(v);
            send_op(ACT_LOAD, v + {16'd0, off}, off, k == n - 1);
            if (shuffle) v = $urandom();
            else v = v - ((span == 0) ? $urandom_range(1 << 20) : $urandom_range(2));
        end
    endtask

    task automatic test_empty();
        send_op(ACT_FIRST);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'hFFFF_FFFF);
        send_op(ACT_LOWER);
    endtask

    task automatic test_directed();
        send_op(ACT_CLEAR);
        send_op(ACT_LOAD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_op(ACT_LOAD, 32'h0000_8000, 16'hFFFF, 1'b0);
        send_op(ACT_LOAD, 32'h0000_0001, 16'hFFFF, 1'b1);
        send_op(ACT_LOAD, 32'hFFFF_0000, 16'h0000, 1'b0);
        send_op(ACT_LOAD, 32'h0000_0000, 16'h0000, 1'b1);
        send_op(ACT_LOAD, 32'h0000_0005, 16'h0005, 1'b1);
        send_op(ACT_LOAD, 32'h1234_5678, 16'h0001, 1'b0);
        send_op(ACT_FIRST);
        send_op(ACT_LOWER);
        send_op(ACT_LOWER);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'h0000_0000);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'hFFFF_FFFF);
        send_op(ACT_LOWER);
        send_op(ACT_LOWER);
        send_op(ACT_LOWER);
        send_op(ACT_LOWER);
        send_op(ACT_LOWER);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_unused_actions();
        for (logic [3:0] a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_op(a[2:0], $urandom(), 16'($urandom()), 1'b1, $urandom());
        send_op(ACT_FIRST);
    endtask

    task automatic test_all_lists_used();
        send_op(ACT_CLEAR);
        for (int l = 0; l < N_LISTS; l++)
            send_op(ACT_LOAD, $urandom(), 16'($urandom()), 1'b1);
        send_op(ACT_LOAD, $urandom(), 16'($urandom()), 1'b1);
        send_op(ACT_LOAD, $urandom(), 16'($urandom()), 1'b0);
        send_op(ACT_FIRST);
        send_op(ACT_BOUND, '0, '0, 1'b0, $urandom());
        send_op(ACT_LOWER);
    endtask

    task automatic test_open_list_full();
        send_op(ACT_CLEAR);
        for (int k = 0; k < N_HITS + 2; k++)
            send_op(ACT_LOAD, 32'hF000_0000 - k * 16, 16'h0010, k == N_HITS + 1);
        send_op(ACT_LOAD, 32'h0000_0100, 16'h0000, 1'b1);
        send_op(ACT_FIRST);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'h8000_0000);
        send_op(ACT_LOWER);
        send_op(ACT_BOUND, '0, '0, 1'b0, 32'h0000_0100);
    endtask

    task automatic test_random(int unsigned total);
        int unsigned sent, nl, span;
        logic [31:0] b;
        sent = 0;
        while (sent < total) begin
            calm = (sent > total / 3 && sent < total / 2);
            val_pool.delete();
            send_op(ACT_CLEAR);
            nl = ($urandom_range(9) == 0) ? $urandom_range(N_LISTS + 2, 20)
                                          : $urandom_range(6, 1);
            span = ($urandom_range(1) == 0) ? 0 : $urandom_range(1000, 4);
            for (int l = 0; l < nl; l++)
                load_list($urandom_range(nl > 10 ? 3 : 7, 1),
                          16'(($urandom_range(2) == 0) ? $urandom() : $urandom_range(8)),
                          $urandom_range(15) == 0, span);
            sent += nl * 3 + 1;
            if ($urandom_range(3) == 0) begin
                send_op(ACT_LOAD, $urandom(), 16'($urandom()), 1'b0);
                sent++;
            end
            for (int q = $urandom_range(16, 4); q > 0; q--) begin
                b = (val_pool.size() != 0 && $urandom_range(2) != 0)
                    ? val_pool[$urandom_range(val_pool.size() - 1)] + $urandom_range(2) - 1
                    : $urandom();
                case ($urandom_range(19))
                    0:       send_op(ACT_FIRST);
                    1:       send_op(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)));
                    2, 3, 4, 5, 6: send_op(ACT_BOUND, $urandom(), 16'($urandom()), 1'b0, b);
                    default: send_op(ACT_LOWER);
                endcase
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        merge_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty();
        test_directed();
        test_unused_actions();
        test_all_lists_used();
        test_open_list_full();
        test_random(1210);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("offset_hit_list_merge_engine_unit_tb passed");
        else
            $display("offset_hit_list_merge_engine_unit_tb failed");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
sv/ohlm_pkg.sv
sv/ohlm_ram.sv
sv/ohlm_ctrl.sv
sv/ohlm_dp.sv
sv/offset_hit_list_merge_engine_unit.sv
tb/sv/offset_hit_list_merge_engine_unit_tb.sv
